// ===== rtl/gog_pkg.sv =====
package gog_pkg;

	typedef logic [7:0] pix_t;

	// tile modes as sampled at a tile's first pixel; the unused code behaves as copy
	typedef enum logic [1:0] {
		MODE_COPY    = 2'd0,
		MODE_CLEAR   = 2'd1,
		MODE_OUTLINE = 2'd2
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_FORE   = 2'd0,
		REG_STROKE = 2'd1,
		REG_CLEAR  = 2'd2,
		REG_WHITE  = 2'd3
	} reg_idx_t;

	localparam pix_t FORE_RST   = 8'd15;
	localparam pix_t STROKE_RST = 8'd16;
	localparam pix_t CLEAR_RST  = 8'd0;
	localparam pix_t WHITE_RST  = 8'd15;

	typedef struct packed {
		pix_t fore;
		pix_t stroke;
		pix_t clear;
		pix_t white;
	} colors_t;

	// centre and six 3x3 neighbours of one pixel (no up-left or down-right) with in-tile flags for the four sides
	typedef struct packed {
		pix_t centre;
		pix_t left;
		pix_t right;
		pix_t up;
		pix_t up_right;
		pix_t down;
		pix_t down_left;
		logic has_left;
		logic has_right;
		logic has_up;
		logic has_down;
	} window_t;

endpackage

// ===== rtl/gog_pix_if.sv =====
interface gog_pix_if;
	import gog_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] mode;
	pix_t       shape_color;
	pix_t       pixel;

	modport source (output valid, output mode, output shape_color, output pixel, input ready);
	modport sink   (input valid, input mode, input shape_color, input pixel, output ready);

endinterface

// ===== rtl/gog_res_if.sv =====
interface gog_res_if;
	import gog_pkg::*;

	logic valid;
	logic ready;
	pix_t out_pixel;
	logic tile_last;

	modport source (output valid, output out_pixel, output tile_last, input ready);
	modport sink   (input valid, input out_pixel, input tile_last, output ready);

endinterface

// ===== rtl/gog_cfg_if.sv =====
interface gog_cfg_if;
	import gog_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] index;
	pix_t       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);

endinterface

// ===== rtl/glyph_outline_generator.sv =====
// a pixel of row r (r > 0) in the input stage yields the registered pixel above it
// throughput: one pixel per cycle unless res_out.ready holds the result stage;
// after a tile's last pixel the final row is drained, during which pix_in.ready is low
// reset: clears the tile position, tile mode and shape colour, valid flags and the
// colour registers to their defaults; the row shift line holds no reset
module glyph_outline_generator #(
	parameter int GLYPH_SIDE = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	gog_pix_if.sink pix_in,
	gog_res_if.source res_out,
	gog_cfg_if.sink cfg
);
	import gog_pkg::*;

	localparam int CW    = (GLYPH_SIDE > 1) ? $clog2(GLYPH_SIDE) : 1;
	localparam int RW    = $clog2(GLYPH_SIDE + 1);
	localparam int DEPTH = 2 * GLYPH_SIDE;

	localparam logic [CW-1:0] COL_LAST  = CW'(GLYPH_SIDE - 1);
	localparam logic [RW-1:0] ROW_FLUSH = RW'(GLYPH_SIDE);
	localparam logic [RW-1:0] ROW_TWO   = RW'(2);

	colors_t colors;

	// tile position of the next word, row GLYPH_SIDE being the drain of the final row
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    tile_mode_q;
	pix_t          tile_shape_q;

	// input stage
	logic          valid_s1;
	pix_t          pixel_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;

	// result stage
	logic valid_s2;
	pix_t out_pixel_s2;
	logic tile_last_s2;

	// raster shift line over the last two rows, entry 0 the most recent pixel
	pix_t sh_q [DEPTH];

	logic    flushing;
	logic    s2_free;
	logic    s1_go;
	logic    s1_load;
	logic    take;
	logic    advance;
	logic    s1_nores;
	logic    tile_start;
	window_t win;
	pix_t    shaded;

	gog_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.colors (colors)
	);

	// handshake and stage flow
	assign flushing   = (row_q == ROW_FLUSH);
	assign s2_free    = !valid_s2 || res_out.ready;
	assign s1_nores   = (row_s1 == '0);
	assign s1_go      = valid_s1 && (s1_nores || s2_free);
	assign s1_load    = !valid_s1 || s1_go;
	assign pix_in.ready = s1_load && !flushing;
	assign take       = pix_in.valid && pix_in.ready;
	assign advance    = take || (s1_load && flushing);
	assign tile_start = (row_q == '0) && (col_q == '0);

	// tile position counter and tile attributes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			tile_mode_q  <= MODE_COPY;
			tile_shape_q <= '0;
		end else begin
			if (advance) begin
				if (col_q == COL_LAST) begin
					col_q <= '0;
					row_q <= flushing ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (take && tile_start) begin
				tile_mode_q  <= pix_in.mode;
				tile_shape_q <= pix_in.shape_color;
			end
		end
	end

	// input stage register; drain slots carry no pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			row_s1   <= '0;
			col_s1   <= '0;
		end else if (s1_load) begin
			valid_s1 <= advance;
			if (advance) begin
				row_s1 <= row_q;
				col_s1 <= col_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			pixel_s1 <= pix_in.pixel;
	end

	// shift line moves on as each word leaves the input stage
	always_ff @(posedge clk) begin
		if (s1_go) begin
			sh_q[0] <= pixel_s1;
			for (int i = 1; i < DEPTH; i++)
				sh_q[i] <= sh_q[i-1];
		end
	end

	// neighbourhood of the pixel one row above the word in the input stage
	always_comb begin
		win.centre    = sh_q[GLYPH_SIDE-1];
		win.left      = sh_q[GLYPH_SIDE];
		win.right     = sh_q[GLYPH_SIDE-2];
		win.up        = sh_q[DEPTH-1];
		win.up_right  = sh_q[DEPTH-2];
		win.down      = pixel_s1;
		win.down_left = sh_q[0];
		win.has_left  = (col_s1 != '0);
		win.has_right = (col_s1 != COL_LAST);
		win.has_up    = (row_s1 >= ROW_TWO);
		win.has_down  = (row_s1 != ROW_FLUSH);
	end

	gog_shade u_shade (
		.win         (win),
		.tile_mode   (tile_mode_q),
		.shape_color (tile_shape_q),
		.colors      (colors),
		.result      (shaded)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && !s1_nores) begin
			valid_s2 <= 1'b1;
		end else if (res_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && !s1_nores) begin
			out_pixel_s2 <= shaded;
			tile_last_s2 <= (row_s1 == ROW_FLUSH) && (col_s1 == COL_LAST);
		end
	end

	assign res_out.valid     = valid_s2;
	assign res_out.out_pixel = out_pixel_s2;
	assign res_out.tile_last = tile_last_s2;

	// no new word is taken while the final row drains
	a_no_take_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		flushing |-> !pix_in.ready)
		else $error("pixel taken while draining the final row");

	// tile attributes change only when a tile's first pixel is taken
	a_mode_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(tile_mode_q != $past(tile_mode_q) || tile_shape_q != $past(tile_shape_q))
		|-> $past(take && tile_start))
		else $error("tile attributes changed inside a tile");

	// the last drain slot leaving the input stage becomes a tile_last result
	a_last_marks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && row_s1 == ROW_FLUSH && col_s1 == COL_LAST |=> valid_s2 && tile_last_s2)
		else $error("tile_last missing on final pixel");

	// column and row counters stay inside the tile and its drain row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LAST && row_q <= ROW_FLUSH)
		else $error("tile position out of range");

endmodule

// ===== rtl/gog_cfg_regs.sv =====
module gog_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	gog_cfg_if.sink          cfg,
	output gog_pkg::colors_t colors
);
	import gog_pkg::*;

	colors_t colors_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// colour register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q.fore   <= FORE_RST;
			colors_q.stroke <= STROKE_RST;
			colors_q.clear  <= CLEAR_RST;
			colors_q.white  <= WHITE_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_FORE:   colors_q.fore   <= cfg.data;
				REG_STROKE: colors_q.stroke <= cfg.data;
				REG_CLEAR:  colors_q.clear  <= cfg.data;
				REG_WHITE:  colors_q.white  <= cfg.data;
				default:    colors_q        <= colors_q;
			endcase
		end
	end

	assign colors = colors_q;

endmodule

// ===== rtl/gog_shade.sv =====
module gog_shade (
	input  gog_pkg::window_t win,
	input  logic [1:0]       tile_mode,
	input  gog_pkg::pix_t    shape_color,
	input  gog_pkg::colors_t colors,
	output gog_pkg::pix_t    result
);
	import gog_pkg::*;

	logic hit;

	// outline test: up-left and down-right are deliberately not looked at
	always_comb begin
		hit = (win.has_left && win.left == shape_color)
			|| (win.has_right && win.right == shape_color)
			|| (win.has_up && win.up == shape_color)
			|| (win.has_up && win.has_right && win.up_right == shape_color)
			|| (win.has_down && win.down == shape_color)
			|| (win.has_down && win.has_left && win.down_left == shape_color);
	end

	// colour selection per mode
	always_comb begin
		case (tile_mode)
			MODE_CLEAR:
				result = (win.centre == colors.white) ? colors.clear : win.centre;
			MODE_OUTLINE: begin
				if (win.centre == shape_color)
					result = colors.fore;
				else if (hit)
					result = colors.stroke;
				else
					result = colors.clear;
			end
			default:
				result = win.centre;
		endcase
	end

endmodule
